>>> src/gzcl_pkg.sv
// Package for the grid zero-crossing lock detector.
// Holds field widths, register indexes and reset defaults; no dependencies.
`default_nettype none
package gzcl_pkg;

    localparam int LEVEL_W   = 12;
    localparam int PERIOD_W  = 17;
    localparam int TIMEOUT_W = 20;
    localparam int COUNT_W   = 16;
    localparam int TIME_W    = 32;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 20;

    localparam int DEF_WINDOW      = 5;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_MAX_FOLDS   = 8;

    typedef enum logic [IDX_W-1:0] {
        REG_ZERO_LEVEL   = 3'd0,
        REG_CYCLE_PERIOD = 3'd1,
        REG_WINDOW_LOW   = 3'd2,
        REG_WINDOW_HIGH  = 3'd3,
        REG_LOSS_TIMEOUT = 3'd4,
        REG_LOCK_COUNT   = 3'd5
    } cfg_reg_t;

    localparam logic [LEVEL_W-1:0]   RST_ZERO_LEVEL   = 12'd1971;
    localparam logic [PERIOD_W-1:0]  RST_CYCLE_PERIOD = 17'd20000;
    localparam logic [PERIOD_W-1:0]  RST_WINDOW_LOW   = 17'd19500;
    localparam logic [PERIOD_W-1:0]  RST_WINDOW_HIGH  = 17'd20500;
    localparam logic [TIMEOUT_W-1:0] RST_LOSS_TIMEOUT = 20'd100000;
    localparam logic [COUNT_W-1:0]   RST_LOCK_COUNT   = 16'd10000;

endpackage
`default_nettype wire

>>> src/gzcl_if.sv
// Channel interfaces: sample items in, result items out, register writes.
// Depends on gzcl_pkg.
`default_nettype none
interface gzcl_sample_if #(
    parameter int SAMPLE_BITS = gzcl_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic [SAMPLE_BITS-1:0]        adc_sample;
    logic [gzcl_pkg::TIME_W-1:0]   sample_time;

    modport source (output valid, output adc_sample, output sample_time, input ready);
    modport sink   (input valid, input adc_sample, input sample_time, output ready);
endinterface

interface gzcl_result_if;
    logic                          valid;
    logic                          ready;
    logic [gzcl_pkg::LEVEL_W-1:0]  filtered_level;
    logic                          edge_accepted;
    logic [gzcl_pkg::PERIOD_W-1:0] edge_interval;
    logic [gzcl_pkg::TIME_W-1:0]   edge_time;
    logic                          grid_locked;

    modport source (output valid, output filtered_level, output edge_accepted,
                    output edge_interval, output edge_time, output grid_locked,
                    input ready);
    modport sink   (input valid, input filtered_level, input edge_accepted,
                    input edge_interval, input edge_time, input grid_locked,
                    output ready);
endinterface

interface gzcl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gzcl_pkg::IDX_W-1:0]    index;
    logic [gzcl_pkg::DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/grid_zero_cross_lock_detector.sv
// Grid zero-crossing lock detector: moving average, rising-crossing detect,
// interval folding and lock tracking under one small sequencer.
// Depends on gzcl_pkg and the interfaces in gzcl_if.sv.
// A sample steps through SUM, MUL, DIV, EDGE; on a rising crossing after a held
//   edge it also goes through FOLD (F subtractions, 0..MAX_FOLDS), then to DONE.
// No new sample is taken until the item leaves DONE; the fold step subtracts the
//   cycle period while the interval is above the high window bound.
// A finished result waits in an output register while the next item is taken.
// Reset (async, active low) clears the window, history, lock and restores
// register defaults; no clearing pass.
`default_nettype none
module grid_zero_cross_lock_detector #(
    parameter int WINDOW      = gzcl_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = gzcl_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_FOLDS   = gzcl_pkg::DEF_MAX_FOLDS
) (
    input  wire            clk,
    input  wire            rst_n,
    gzcl_sample_if.sink    samples,
    gzcl_result_if.source  results,
    gzcl_cfg_if.sink       cfg
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FOLD_W = $clog2(MAX_FOLDS + 1);
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam int TW     = gzcl_pkg::TIME_W;
    localparam logic [SUM_W:0] RECIP = (SUM_W+1)'((64'd1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
    localparam logic [FOLD_W-1:0] FOLD_CAP = FOLD_W'(MAX_FOLDS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SUM, ST_MUL, ST_DIV, ST_EDGE, ST_FOLD, ST_DONE
    } state_t;

    // configuration registers
    logic [gzcl_pkg::LEVEL_W-1:0]   zero_level_reg;
    logic [gzcl_pkg::PERIOD_W-1:0]  cycle_period_reg;
    logic [gzcl_pkg::PERIOD_W-1:0]  window_low_reg;
    logic [gzcl_pkg::PERIOD_W-1:0]  window_high_reg;
    logic [gzcl_pkg::TIMEOUT_W-1:0] loss_timeout_reg;
    logic [gzcl_pkg::COUNT_W-1:0]   lock_count_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_level_reg   <= gzcl_pkg::RST_ZERO_LEVEL;
            cycle_period_reg <= gzcl_pkg::RST_CYCLE_PERIOD;
            window_low_reg   <= gzcl_pkg::RST_WINDOW_LOW;
            window_high_reg  <= gzcl_pkg::RST_WINDOW_HIGH;
            loss_timeout_reg <= gzcl_pkg::RST_LOSS_TIMEOUT;
            lock_count_reg   <= gzcl_pkg::RST_LOCK_COUNT;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                gzcl_pkg::REG_ZERO_LEVEL:   zero_level_reg   <= cfg.data[gzcl_pkg::LEVEL_W-1:0];
                gzcl_pkg::REG_CYCLE_PERIOD: cycle_period_reg <= cfg.data[gzcl_pkg::PERIOD_W-1:0];
                gzcl_pkg::REG_WINDOW_LOW:   window_low_reg   <= cfg.data[gzcl_pkg::PERIOD_W-1:0];
                gzcl_pkg::REG_WINDOW_HIGH:  window_high_reg  <= cfg.data[gzcl_pkg::PERIOD_W-1:0];
                gzcl_pkg::REG_LOSS_TIMEOUT: loss_timeout_reg <= cfg.data[gzcl_pkg::TIMEOUT_W-1:0];
                gzcl_pkg::REG_LOCK_COUNT:   lock_count_reg   <= cfg.data[gzcl_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state and datapath registers
    state_t                         state_reg, state_next;
    logic [SAMPLE_BITS-1:0]         win_reg [WINDOW];
    logic [SAMPLE_BITS-1:0]         win_next [WINDOW];
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [SAMPLE_BITS-1:0]         sample_reg, sample_next;
    logic [TW-1:0]                  now_reg, now_next;
    logic [TW-1:0]                  itv_reg, itv_next;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0]         cur_reg, cur_next;
    logic [SAMPLE_BITS-1:0]         prev_reg, prev_next;
    logic [TW-1:0]                  acc_reg, acc_next;
    logic [FOLD_W-1:0]              nfold_reg, nfold_next;
    logic                           hit_reg, hit_next;
    logic [TW-1:0]                  last_time_reg, last_time_next;
    logic                           seen_reg, seen_next;
    logic [gzcl_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                           lock_reg, lock_next;
    logic [gzcl_pkg::PERIOD_W-1:0]  held_itv_reg, held_itv_next;
    logic [TW-1:0]                  held_time_reg, held_time_next;
    // output register
    logic                           ovalid_reg, ovalid_next;
    logic [gzcl_pkg::LEVEL_W-1:0]   olevel_reg, olevel_next;
    logic                           ohit_reg, ohit_next;
    logic [gzcl_pkg::PERIOD_W-1:0]  oitv_reg, oitv_next;
    logic [TW-1:0]                  otime_reg, otime_next;
    logic                           olock_reg, olock_next;

    logic [SUM_W-1:0]               q_est;
    logic [SUM_W-1:0]               q_rem;
    logic                           rising;
    logic [gzcl_pkg::COUNT_W-1:0]   count_inc;

    assign samples.ready          = (state_reg == ST_IDLE);
    assign results.valid          = ovalid_reg;
    assign results.filtered_level = olevel_reg;
    assign results.edge_accepted  = ohit_reg;
    assign results.edge_interval  = oitv_reg;
    assign results.edge_time      = otime_reg;
    assign results.grid_locked    = olock_reg;

    // reciprocal estimate is at most one low; one compare fixes it
    assign q_est  = SUM_W'(prod_reg >> SUM_W);
    assign q_rem  = sum_reg - SUM_W'(q_est * WIN_C);
    assign rising = (TW'(prev_reg) <= TW'(zero_level_reg))
                 && (TW'(cur_reg) > TW'(zero_level_reg));
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        sample_next    = sample_reg;
        now_next       = now_reg;
        itv_next       = itv_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        acc_next       = acc_reg;
        nfold_next     = nfold_reg;
        hit_next       = hit_reg;
        last_time_next = last_time_reg;
        seen_next      = seen_reg;
        count_next     = count_reg;
        lock_next      = lock_reg;
        held_itv_next  = held_itv_reg;
        held_time_next = held_time_reg;
        ovalid_next    = ovalid_reg;
        olevel_next    = olevel_reg;
        ohit_next      = ohit_reg;
        oitv_next      = oitv_reg;
        otime_next     = otime_reg;
        olock_next     = olock_reg;

        if (ovalid_reg && results.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    sample_next = samples.adc_sample;
                    now_next    = samples.sample_time;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next = sum_reg - SUM_W'(win_reg[pos_reg]) + SUM_W'(sample_reg);
                win_next[pos_reg] = sample_reg;
                pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                itv_next = now_reg - last_time_reg;
                hit_next = 1'b0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next = PROD_W'(sum_reg * RECIP);
                // loss of grid is judged before edge detection
                if (seen_reg && (itv_reg > TW'(loss_timeout_reg)))
                begin
                    lock_next  = 1'b0;
                    count_next = '0;
                    seen_next  = 1'b0;
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cur_next   = SAMPLE_BITS'((q_rem >= WIN_C) ? q_est + 1'b1 : q_est);
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                prev_next  = cur_reg;
                state_next = ST_DONE;
                if (rising)
                begin
                    if (!seen_reg)
                    begin
                        last_time_next = now_reg;
                        seen_next      = 1'b1;
                    end
                    else
                    begin
                        acc_next   = itv_reg;
                        nfold_next = '0;
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_FOLD:
            begin
                if (acc_reg > TW'(window_high_reg))
                begin
                    if ((nfold_reg == FOLD_CAP) || (acc_reg < TW'(cycle_period_reg)))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        acc_next   = acc_reg - TW'(cycle_period_reg);
                        nfold_next = nfold_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                    if (acc_reg >= TW'(window_low_reg))
                    begin
                        hit_next       = 1'b1;
                        held_itv_next  = acc_reg[gzcl_pkg::PERIOD_W-1:0];
                        held_time_next = now_reg;
                        last_time_next = now_reg;
                        if (count_reg < lock_count_reg)
                        begin
                            count_next = count_inc;
                            if (count_inc == lock_count_reg)
                            begin
                                lock_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || results.ready)
                begin
                    ovalid_next = 1'b1;
                    olevel_next = gzcl_pkg::LEVEL_W'(cur_reg);
                    ohit_next   = hit_reg;
                    oitv_next   = held_itv_reg;
                    otime_next  = held_time_reg;
                    olock_next  = lock_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg       <= '0;
            pos_reg       <= '0;
            prev_reg      <= '0;
            hit_reg       <= 1'b0;
            last_time_reg <= '0;
            seen_reg      <= 1'b0;
            count_reg     <= '0;
            lock_reg      <= 1'b0;
            held_itv_reg  <= '0;
            held_time_reg <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            hit_reg       <= hit_next;
            last_time_reg <= last_time_next;
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            lock_reg      <= lock_next;
            held_itv_reg  <= held_itv_next;
            held_time_reg <= held_time_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        now_reg    <= now_next;
        itv_reg    <= itv_next;
        prod_reg   <= prod_next;
        cur_reg    <= cur_next;
        acc_reg    <= acc_next;
        nfold_reg  <= nfold_next;
        olevel_reg <= olevel_next;
        ohit_reg   <= ohit_next;
        oitv_reg   <= oitv_next;
        otime_reg  <= otime_next;
        olock_reg  <= olock_next;
    end

`ifndef SYNTHESIS
    a_lock_needs_edge: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> seen_reg)
        else $error("lock set without a held edge time");

    a_fold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> (seen_reg && (nfold_reg <= FOLD_CAP)))
        else $error("fold step outside its bounds");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("window position out of range");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!ovalid_reg || results.ready))
            |=> (ovalid_reg && (state_reg == ST_IDLE)))
        else $error("finished item not moved to output register");
`endif

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Testbench for grid_zero_cross_lock_detector: a scoreboard class predicts each result item
// from the accepted samples and checks the result channel in order.
// Depends on gzcl_pkg, the interfaces in gzcl_if.sv and the RTL top level.

typedef struct packed {
    logic [gzcl_pkg::LEVEL_W-1:0]  level;
    logic                          accepted;
    logic [gzcl_pkg::PERIOD_W-1:0] interval;
    logic [gzcl_pkg::TIME_W-1:0]   stamp;
    logic                          locked;
} lock_result_t;

class lock_scoreboard;
    localparam int WIN   = gzcl_pkg::DEF_WINDOW;
    localparam int FOLDS = gzcl_pkg::DEF_MAX_FOLDS;

    logic [gzcl_pkg::LEVEL_W-1:0]   zero_level;
    logic [gzcl_pkg::PERIOD_W-1:0]  cycle_period;
    logic [gzcl_pkg::PERIOD_W-1:0]  window_low;
    logic [gzcl_pkg::PERIOD_W-1:0]  window_high;
    logic [gzcl_pkg::TIMEOUT_W-1:0] loss_timeout;
    logic [gzcl_pkg::COUNT_W-1:0]   lock_count;

    logic [gzcl_pkg::LEVEL_W-1:0]  taps[WIN];
    logic [14:0]                   tap_sum;
    int                            tap_pos;
    logic [gzcl_pkg::LEVEL_W-1:0]  prev_level;
    logic [gzcl_pkg::TIME_W-1:0]   last_edge;
    bit                            edge_held;
    logic [gzcl_pkg::COUNT_W-1:0]  good_edges;
    bit                            grid_lock;
    logic [gzcl_pkg::PERIOD_W-1:0] held_itv;
    logic [gzcl_pkg::TIME_W-1:0]   held_stamp;

    lock_result_t pending[$];
    int errors;

    function new();
        zero_level   = gzcl_pkg::RST_ZERO_LEVEL;
        cycle_period = gzcl_pkg::RST_CYCLE_PERIOD;
        window_low   = gzcl_pkg::RST_WINDOW_LOW;
        window_high  = gzcl_pkg::RST_WINDOW_HIGH;
        loss_timeout = gzcl_pkg::RST_LOSS_TIMEOUT;
        lock_count   = gzcl_pkg::RST_LOCK_COUNT;
        foreach (taps[i]) taps[i] = '0;
        tap_sum    = '0;
        tap_pos    = 0;
        prev_level = '0;
        last_edge  = '0;
        edge_held  = 1'b0;
        good_edges = '0;
        grid_lock  = 1'b0;
        held_itv   = '0;
        held_stamp = '0;
        errors     = 0;
    endfunction

    function void set_reg(logic [gzcl_pkg::IDX_W-1:0] idx, logic [gzcl_pkg::DATA_W-1:0] val);
        case (idx)
            gzcl_pkg::REG_ZERO_LEVEL:   zero_level   = val[gzcl_pkg::LEVEL_W-1:0];
            gzcl_pkg::REG_CYCLE_PERIOD: cycle_period = val[gzcl_pkg::PERIOD_W-1:0];
            gzcl_pkg::REG_WINDOW_LOW:   window_low   = val[gzcl_pkg::PERIOD_W-1:0];
            gzcl_pkg::REG_WINDOW_HIGH:  window_high  = val[gzcl_pkg::PERIOD_W-1:0];
            gzcl_pkg::REG_LOSS_TIMEOUT: loss_timeout = val[gzcl_pkg::TIMEOUT_W-1:0];
            gzcl_pkg::REG_LOCK_COUNT:   lock_count   = val[gzcl_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Fold by whole periods while above the window; underflow or running out of folds rejects.
    function bit fold_gap(logic [gzcl_pkg::TIME_W-1:0] gap,
                          output logic [gzcl_pkg::TIME_W-1:0] folded);
        folded = gap;
        for (int n = 0; n < FOLDS && folded > window_high; n++)
        begin
            if (folded < cycle_period)
                return 1'b0;
            folded -= cycle_period;
        end
        return folded <= window_high;
    endfunction

    function void note_sample(logic [gzcl_pkg::LEVEL_W-1:0] val,
                              logic [gzcl_pkg::TIME_W-1:0] now);
        logic [gzcl_pkg::TIME_W-1:0]  gap;
        logic [gzcl_pkg::TIME_W-1:0]  folded;
        logic [gzcl_pkg::LEVEL_W-1:0] level;
        lock_result_t                 want;
        tap_sum = tap_sum - taps[tap_pos] + val;
        taps[tap_pos] = val;
        tap_pos = (tap_pos + 1) % WIN;
        level = gzcl_pkg::LEVEL_W'(tap_sum / WIN);
        gap = now - last_edge;
        want.accepted = 1'b0;
        if (edge_held && gap > loss_timeout)
        begin
            grid_lock  = 1'b0;
            good_edges = '0;
            edge_held  = 1'b0;
        end
        if (prev_level <= zero_level && level > zero_level)
        begin
            if (!edge_held)
            begin
                last_edge = now;
                edge_held = 1'b1;
            end
            else if (fold_gap(gap, folded) && folded >= window_low)
            begin
                want.accepted = 1'b1;
                held_itv   = folded[gzcl_pkg::PERIOD_W-1:0];
                held_stamp = now;
                last_edge  = now;
                if (good_edges < lock_count)
                begin
                    good_edges++;
                    if (good_edges == lock_count)
                        grid_lock = 1'b1;
                end
            end
        end
        prev_level = level;
        want.level    = level;
        want.interval = held_itv;
        want.stamp    = held_stamp;
        want.locked   = grid_lock;
        pending.push_back(want);
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_result(logic [gzcl_pkg::LEVEL_W-1:0] level, logic accepted,
                      logic [gzcl_pkg::PERIOD_W-1:0] interval,
                      logic [gzcl_pkg::TIME_W-1:0] stamp, logic locked);
        lock_result_t want;
        if (pending.size() == 0)
        begin
            report("result item with no sample pending");
            return;
        end
        want = pending.pop_front();
        if (level !== want.level)
            report($sformatf("filtered_level expected %0d got %0d", want.level, level));
        if (accepted !== want.accepted)
            report($sformatf("edge_accepted expected %0b got %0b", want.accepted, accepted));
        if (interval !== want.interval)
            report($sformatf("edge_interval expected %0d got %0d", want.interval, interval));
        if (stamp !== want.stamp)
            report($sformatf("edge_time expected %0h got %0h", want.stamp, stamp));
        if (locked !== want.locked)
            report($sformatf("grid_locked expected %0b got %0b", want.locked, locked));
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    localparam logic [gzcl_pkg::IDX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [gzcl_pkg::IDX_W-1:0] IDX_SPARE_B = 3'd7;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 210;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int send_idle = 0;
    int stall_pct = 0;
    int fed = 0;

    lock_scoreboard sb = new();

    gzcl_sample_if smp();
    gzcl_result_if res();
    gzcl_cfg_if    cfg();

    grid_zero_cross_lock_detector uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp),
        .results (res),
        .cfg     (cfg)
    );

    always #5 clk = ~clk;

    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid === 1'b1 && res.ready === 1'b1)
            sb.check_result(res.filtered_level, res.edge_accepted, res.edge_interval,
                            res.edge_time, res.grid_locked);
    end

    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic push_sample(input logic [gzcl_pkg::LEVEL_W-1:0] val,
                               input logic [gzcl_pkg::TIME_W-1:0] stamp);
        while ($urandom_range(99) < send_idle)
        begin
            smp.valid = 1'b0;
            @(negedge clk);
        end
        smp.valid       = 1'b1;
        smp.adc_sample  = val;
        smp.sample_time = stamp;
        do @(posedge clk); while (smp.ready !== 1'b1);
        sb.note_sample(val, stamp);
        fed++;
        @(negedge clk);
    endtask

    task automatic send_run(input int n, input int lo, input int hi,
                            input logic [gzcl_pkg::TIME_W-1:0] t0, input int step);
        for (int i = 0; i < n; i++)
            push_sample(gzcl_pkg::LEVEL_W'($urandom_range(hi, lo)),
                        gzcl_pkg::TIME_W'(t0 + i * step));
    endtask

    task automatic drain();
        smp.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Leaves the write valid high; the caller drops it after the last register.
    task automatic write_reg(input logic [gzcl_pkg::IDX_W-1:0] idx,
                             input logic [gzcl_pkg::DATA_W-1:0] val);
        int w;
        case (idx)
            gzcl_pkg::REG_ZERO_LEVEL:   w = gzcl_pkg::LEVEL_W;
            gzcl_pkg::REG_LOSS_TIMEOUT: w = gzcl_pkg::TIMEOUT_W;
            gzcl_pkg::REG_LOCK_COUNT:   w = gzcl_pkg::COUNT_W;
            default:                    w = gzcl_pkg::PERIOD_W;
        endcase
        // junk above the register width must be dropped by the block
        cfg.data  = val | (gzcl_pkg::DATA_W'($urandom) & ~gzcl_pkg::DATA_W'((1 << w) - 1));
        cfg.index = idx;
        cfg.valid = 1'b1;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        sb.set_reg(idx, cfg.data);
        @(negedge clk);
    endtask

    task automatic configure(input int k);
        int zl, per, lo, hi, lim, need;
        zl   = $urandom_range(4095);
        per  = 20000;
        lo   = 19500;
        hi   = 20500;
        lim  = 100000;
        need = $urandom_range(6, 1);
        case (k)
            0:
            begin
                zl   = 1971;
                need = 3;
            end
            1:
            begin
                zl   = 0;
                per  = 1;
                lo   = 0;
                hi   = 131071;
                lim  = 1048575;
                need = 1;
            end
            2:
            begin
                zl   = 4095;
                per  = 131071;
                lo   = 131071;
                hi   = 131071;
                lim  = 0;
                need = 65535;
            end
            // window below the period: folds can underflow
            3:
            begin
                lo   = 5000;
                hi   = 15000;
                lim  = 300000;
                need = 2;
            end
            // short period, long gaps run out of folds; zero count never locks
            4:
            begin
                per  = 1000;
                lo   = 900;
                hi   = 1100;
                lim  = 20000;
                need = 0;
            end
            5:
            begin
                per = $urandom_range(131071, 1);
                lo  = $urandom_range(131071);
                hi  = $urandom_range(131071);
                lim = $urandom_range(1048575);
            end
            6: need = 40;
            default: need = 2;   // below the count left from the phase before
        endcase
        write_reg(gzcl_pkg::REG_ZERO_LEVEL, gzcl_pkg::DATA_W'(zl));
        write_reg(gzcl_pkg::REG_CYCLE_PERIOD, gzcl_pkg::DATA_W'(per));
        write_reg(gzcl_pkg::REG_WINDOW_LOW, gzcl_pkg::DATA_W'(lo));
        write_reg(gzcl_pkg::REG_WINDOW_HIGH, gzcl_pkg::DATA_W'(hi));
        write_reg(gzcl_pkg::REG_LOSS_TIMEOUT, gzcl_pkg::DATA_W'(lim));
        write_reg(gzcl_pkg::REG_LOCK_COUNT, gzcl_pkg::DATA_W'(need));
        write_reg(IDX_SPARE_A, gzcl_pkg::DATA_W'($urandom));
        write_reg(IDX_SPARE_B, gzcl_pkg::DATA_W'($urandom));
        cfg.valid = 1'b0;
    endtask

    function automatic logic [gzcl_pkg::TIME_W-1:0] next_gap();
        int r, wl, wh, per;
        longint g;
        wl  = int'(sb.window_low);
        wh  = int'(sb.window_high);
        per = int'(sb.cycle_period);
        r   = $urandom_range(99);
        if (r < 70)
        begin
            g = (wh >= wl) ? wl + $urandom_range(wh - wl) : $urandom_range(wl);
            if ($urandom_range(3) == 0)
                g += longint'($urandom_range(9, 1)) * per;
        end
        else if (r < 80)
            g = $urandom_range(2 * wh + 1);
        else if (r < 90)
            g = longint'(sb.loss_timeout) + $urandom_range(5000, 1);
        else
            g = $urandom;
        return g[gzcl_pkg::TIME_W-1:0];
    endfunction

    task automatic run_phase(input idle_mode_t mode, input int quota);
        int target, r, step, zl, hi_lo;
        logic [gzcl_pkg::TIME_W-1:0] t;
        case (mode)
            IDLE_NONE:
            begin
                send_idle = 0;
                stall_pct = 0;
            end
            IDLE_SEND:
            begin
                send_idle = 73;
                stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle = 0;
                stall_pct = 73;
            end
            default:
            begin
                send_idle = 25;
                stall_pct = 25;
            end
        endcase
        zl     = int'(sb.zero_level);
        hi_lo  = (zl == 4095) ? 4095 : zl + 1;
        target = fed + quota;
        t      = $urandom;
        while (fed < target)
        begin
            r    = $urandom_range(99);
            step = $urandom_range(20);
            if (r < 75)
            begin
                // one clean grid cycle: the window fills low, then rises across the level
                send_run(5, 0, zl, t, step);
                send_run(5, hi_lo, 4095, t + 5 * step, step);
                t += next_gap();
            end
            else if (r < 88)
            begin
                send_run($urandom_range(4, 1), 0, zl, t, step);
                send_run($urandom_range(4, 1), hi_lo, 4095, t + 5 * step, step);
                t += next_gap();
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_run(1, 0, 4095,
                             $urandom_range(1) ? $urandom : t + $urandom_range(50000), 0);
            end
        end
    endtask

    initial
    begin
        logic [gzcl_pkg::TIME_W-1:0] marks[4];
        marks = '{32'd0, 32'd40000, 32'd59499, 32'd60500};
        smp.valid       = 1'b0;
        smp.adc_sample  = '0;
        smp.sample_time = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: extremes, then a first edge at time zero, a folded
        // double period, a too-short interval and one at the high bound
        send_run(1, 0, 0, 32'd0, 0);
        send_run(1, 4095, 4095, 32'hFFFF_FFFF, 0);
        foreach (marks[i])
        begin
            send_run(3, 0, 0, marks[i], 0);
            send_run(3, 4095, 4095, marks[i], 0);
        end

        for (int k = 0; k < PHASES; k++)
        begin
            drain();
            configure(k);
            run_phase(idle_mode_t'(k % 4), PHASE_ITEMS);
        end
        drain();
        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d result items never arrived", sb.pending.size()));
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
